>>> rtl/fkv_pkg.sv
`timescale 1ns / 1ps
// Package for the flash key/value log store: sizes, opcodes, status codes,
// tag markers and word layouts. No dependencies.

package fkv_pkg;

    // Records in one block; the store holds two blocks.
    localparam int RECORDS_PER_BLOCK = 1024;
    localparam int IDX_W  = $clog2(RECORDS_PER_BLOCK);   // index inside a block
    localparam int CNT_W  = IDX_W + 1;                   // 0..RECORDS_PER_BLOCK
    localparam int ADDR_W = IDX_W + 1;                   // block bit + index
    localparam int DEPTH  = 2 * RECORDS_PER_BLOCK;

    localparam logic [CNT_W-1:0] FILL_FULL = CNT_W'(RECORDS_PER_BLOCK);

    // Field widths
    localparam int OP_W   = 2;
    localparam int KEY_W  = 16;
    localparam int VAL_W  = 16;
    localparam int STAT_W = 2;
    localparam int REC_W  = KEY_W + VAL_W;

    // Stream word widths (fields packed from bit 0, padded to bytes)
    localparam int IN_BITS  = OP_W + KEY_W + VAL_W;
    localparam int OUT_BITS = STAT_W + VAL_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Opcodes
    localparam logic [OP_W-1:0] OP_READ16 = 2'd0;
    localparam logic [OP_W-1:0] OP_READ8  = 2'd1;
    localparam logic [OP_W-1:0] OP_WRITE  = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    // Tag markers
    localparam logic [KEY_W-1:0] TAG_ERASED  = 16'hFFFF;
    localparam logic [KEY_W-1:0] TAG_CLEARED = 16'h0000;

endpackage

>>> rtl/flash_kv_log_store.sv
`timescale 1ns / 1ps
// Top level of the flash key/value log store: request/response streams,
// sequencer and the two-block record memory. Depends on fkv_pkg.

// The store keeps 32-bit records (tag in the upper half, value in the lower)
// in one 2 x RECORDS_PER_BLOCK memory with a registered read port. One request
// word is taken at a time and gives exactly one response word. A read scans
// the active block from its first record, one record at a time (address,
// then compare on the registered data), and stops on the first live match
// or on an erased tag. A write scans the same way for an older copy, then
// appends the new record and clears the old tag if there was one. A write
// into a full block first compacts, reading and checking each source record
// in turn, and the following scan then runs over the compacted block; if
// compaction frees no record, the write answers full. The scans are paced
// by the single memory read port. Every scan is bounded by the fill count, so
// no record beyond it is ever examined; the memory needs no clearing pass
// after reset and a request can be taken right away. The response sits in an
// output register, so a new request is taken while an earlier response still
// waits on m_axis_tready.

module flash_kv_log_store
    import fkv_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [1:0] opcode, [17:2] key, [33:18] write_value, upper bits zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [1:0] status, [17:2] read_value, upper bits zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_SCAN_RD  = 9'b000000010,   // issue read of record r_idx
        S_SCAN_CHK = 9'b000000100,   // compare its tag
        S_RESOLVE  = 9'b000001000,   // scan over: answer a read, or go append
        S_APPEND   = 9'b000010000,
        S_CLEAR    = 9'b000100000,   // clear tag of the older copy
        S_COPY_RD  = 9'b001000000,   // compaction: read source record
        S_COPY_CHK = 9'b010000000,   // compaction: copy it if live
        S_DONE     = 9'b100000000    // hand the response to the output reg
    } t_state;

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    t_state              r_state, n_state;
    logic                r_blk, n_blk;           // active block
    logic [CNT_W-1:0]    r_fill, n_fill;         // records used in active block
    logic                r_out_valid, n_out_valid;

    logic [OP_W-1:0]     r_op, n_op;
    logic [KEY_W-1:0]    r_tag, n_tag;
    logic [VAL_W-1:0]    r_wval, n_wval;
    logic [CNT_W-1:0]    r_idx, n_idx;           // scan / copy source index
    logic [CNT_W-1:0]    r_cnt, n_cnt;           // copy destination count
    logic                r_hit, n_hit;
    logic [IDX_W-1:0]    r_hit_idx, n_hit_idx;
    logic [VAL_W-1:0]    r_hit_val, n_hit_val;
    logic [STAT_W-1:0]   r_res_status, n_res_status;
    logic [VAL_W-1:0]    r_res_val, n_res_val;
    logic [STAT_W-1:0]   r_out_status, n_out_status;
    logic [VAL_W-1:0]    r_out_val, n_out_val;

    // Record memory
    logic [REC_W-1:0]    r_mem [DEPTH];
    logic [REC_W-1:0]    r_rdata;
    logic [ADDR_W-1:0]   mem_raddr;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [REC_W-1:0]    mem_wdata;

    // Request fields
    logic [OP_W-1:0]     in_op;
    logic [KEY_W-1:0]    in_key;
    logic [VAL_W-1:0]    in_wval;
    logic [KEY_W-1:0]    in_tag;
    logic                in_reserved;
    logic                accept;

    logic [KEY_W-1:0]    rd_tag;
    logic [VAL_W-1:0]    rd_val;
    logic                out_free;

    assign in_op       = s_axis_tdata[OP_W-1:0];
    assign in_key      = s_axis_tdata[OP_W +: KEY_W];
    assign in_wval     = s_axis_tdata[OP_W+KEY_W +: VAL_W];
    assign in_tag      = in_key + KEY_W'(1);
    assign in_reserved = (in_tag == TAG_ERASED) || (in_tag == TAG_CLEARED);

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign rd_tag = r_rdata[REC_W-1:VAL_W];
    assign rd_val = r_rdata[VAL_W-1:0];

    assign out_free = !r_out_valid || m_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_BITS){1'b0}}, r_out_val, r_out_status};

    // Reads always come from the active block at r_idx
    assign mem_raddr = {r_blk, r_idx[IDX_W-1:0]};

    // ---------------------------------------------------------------
    // Memory: one write port, one registered read port
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb begin
        n_state      = r_state;
        n_blk        = r_blk;
        n_fill       = r_fill;
        n_op         = r_op;
        n_tag        = r_tag;
        n_wval       = r_wval;
        n_idx        = r_idx;
        n_cnt        = r_cnt;
        n_hit        = r_hit;
        n_hit_idx    = r_hit_idx;
        n_hit_val    = r_hit_val;
        n_res_status = r_res_status;
        n_res_val    = r_res_val;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_status = r_out_status;
        n_out_val    = r_out_val;
        mem_we       = 1'b0;
        mem_waddr    = {r_blk, r_fill[IDX_W-1:0]};
        mem_wdata    = {r_tag, r_wval};

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op         = in_op;
                    n_tag        = in_tag;
                    n_wval       = in_wval;
                    n_idx        = '0;
                    n_cnt        = '0;
                    n_hit        = 1'b0;
                    n_res_status = ST_MISS;
                    n_res_val    = '0;
                    if (in_reserved) begin
                        n_state = S_DONE;
                    end else if (in_op inside {OP_READ16, OP_READ8}) begin
                        n_state = S_SCAN_RD;
                    end else if (in_op == OP_WRITE) begin
                        n_state = (r_fill == FILL_FULL) ? S_COPY_RD : S_SCAN_RD;
                    end else begin
                        n_state = S_DONE;   // unused opcode
                    end
                end
            end

            S_SCAN_RD: begin
                n_state = (r_idx == r_fill) ? S_RESOLVE : S_SCAN_CHK;
            end

            S_SCAN_CHK: begin
                if (rd_tag == TAG_ERASED) begin
                    n_state = S_RESOLVE;
                end else if (rd_tag == r_tag) begin
                    n_hit     = 1'b1;
                    n_hit_idx = r_idx[IDX_W-1:0];
                    n_hit_val = rd_val;
                    n_state   = S_RESOLVE;
                end else begin
                    n_idx   = r_idx + CNT_W'(1);
                    n_state = S_SCAN_RD;
                end
            end

            S_RESOLVE: begin
                if (r_op == OP_WRITE) begin
                    n_state = S_APPEND;
                end else begin
                    if (r_hit) begin
                        n_res_status = ST_OK;
                        n_res_val    = (r_op == OP_READ8) ?
                                       {{(VAL_W-8){1'b0}}, r_hit_val[7:0]} : r_hit_val;
                    end
                    n_state = S_DONE;
                end
            end

            S_APPEND: begin
                mem_we       = 1'b1;
                n_fill       = r_fill + CNT_W'(1);
                n_res_status = ST_OK;
                n_state      = r_hit ? S_CLEAR : S_DONE;
            end

            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = {r_blk, r_hit_idx};
                mem_wdata = {TAG_CLEARED, r_hit_val};
                n_state   = S_DONE;
            end

            S_COPY_RD: begin
                if (r_idx == r_fill) begin
                    // source done: swap blocks
                    n_blk  = !r_blk;
                    n_fill = r_cnt;
                    n_idx  = '0;
                    if (r_cnt == FILL_FULL) begin
                        n_res_status = ST_FULL;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_SCAN_RD;
                    end
                end else begin
                    n_state = S_COPY_CHK;
                end
            end

            S_COPY_CHK: begin
                if (rd_tag == TAG_ERASED) begin
                    n_idx = r_fill;          // end of log: finish the copy
                end else begin
                    if (rd_tag != TAG_CLEARED) begin
                        mem_we    = 1'b1;
                        mem_waddr = {!r_blk, r_cnt[IDX_W-1:0]};
                        mem_wdata = r_rdata;
                        n_cnt     = r_cnt + CNT_W'(1);
                    end
                    n_idx = r_idx + CNT_W'(1);
                end
                n_state = S_COPY_RD;
            end

            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_val    = r_res_val;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_blk       <= 1'b0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_blk       <= n_blk;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_tag        <= n_tag;
        r_wval       <= n_wval;
        r_idx        <= n_idx;
        r_cnt        <= n_cnt;
        r_hit        <= n_hit;
        r_hit_idx    <= n_hit_idx;
        r_hit_val    <= n_hit_val;
        r_res_status <= n_res_status;
        r_res_val    <= n_res_val;
        r_out_status <= n_out_status;
        r_out_val    <= n_out_val;
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_FULL)
        else $error("fill count beyond block size");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_APPEND || r_state == S_CLEAR || r_state == S_COPY_CHK))
        else $error("memory write outside append, clear or copy");

    a_copy_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COPY_RD || r_state == S_COPY_CHK) |-> (r_cnt <= r_idx))
        else $error("compaction destination passed its source");

    a_full_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_res_status == ST_FULL) |-> (r_fill == FILL_FULL))
        else $error("full status with room left");

    a_resp_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("response not loaded on completion");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for flash_kv_log_store: drives request words and checks
// every response word against a behavioral copy of the two-block log store.
// Depends on fkv_pkg and the flash_kv_log_store RTL.

module tb
    import fkv_pkg::*;
();

    // opcode 3 has no function; the block must answer with a miss
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [KEY_W-1:0] KEY_RSVD_LO = 16'd65534;   // tag would be erased marker
    localparam logic [KEY_W-1:0] KEY_RSVD_HI = 16'd65535;   // tag would be cleared marker
    localparam logic [KEY_W-1:0] KEY_TOP     = 16'd65533;

    localparam int HOT_KEYS     = 40;
    localparam int RANDOM_WORDS = 290;
    localparam int TAIL_WORDS   = 36;
    // worst word: compaction plus a full rescan, plus stalls on each side;
    // fewer than 2500 words in all
    localparam int DRAIN_CYCLES = 4 * RECORDS_PER_BLOCK + 16;
    localparam int unsigned LIMIT_CYCLES = 2500 * (DRAIN_CYCLES + 12) + 100_000;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  value;
    } t_kv_reply;

    // Behavioral copy of the store plus the queue of replies still owed.
    class kv_scoreboard;
        logic [REC_W-1:0] records [DEPTH];
        bit               bank;
        int unsigned      fill;
        bit               stored_keys [int];
        t_kv_reply        replies_due [$];
        int unsigned      errors;

        function new();
            foreach (records[i]) records[i] = '1;
            bank   = 1'b0;
            fill   = 0;
            errors = 0;
        endfunction

        function int unsigned slot(bit b, int unsigned i);
            return (b ? RECORDS_PER_BLOCK : 0) + i;
        endfunction

        // first live record with this tag, RECORDS_PER_BLOCK if none
        function int unsigned find_live(logic [KEY_W-1:0] tag);
            logic [KEY_W-1:0] t;
            for (int unsigned i = 0; i < fill; i++) begin
                t = records[slot(bank, i)][REC_W-1:VAL_W];
                if (t == TAG_ERASED) break;
                if (t == tag) return i;
            end
            return RECORDS_PER_BLOCK;
        endfunction

        // copy live records, in order, into the erased spare block and swap
        function void compact();
            bit               spare;
            int unsigned      n;
            logic [REC_W-1:0] rec;
            spare = ~bank;
            n     = 0;
            for (int unsigned i = 0; i < RECORDS_PER_BLOCK; i++)
                records[slot(spare, i)] = '1;
            for (int unsigned i = 0; i < fill; i++) begin
                rec = records[slot(bank, i)];
                if (rec[REC_W-1:VAL_W] == TAG_ERASED) break;
                if (rec[REC_W-1:VAL_W] != TAG_CLEARED) begin
                    records[slot(spare, n)] = rec;
                    n++;
                end
            end
            bank = spare;
            fill = n;
        endfunction

        // update the store for an accepted request and queue its reply
        function void apply_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                    logic [VAL_W-1:0] wval);
            logic [KEY_W-1:0] tag;
            bit               reserved;
            int unsigned      idx;
            int unsigned      old;
            t_kv_reply        r;
            tag      = key + 1'b1;
            reserved = (tag == TAG_ERASED) || (tag == TAG_CLEARED);
            r.status = ST_MISS;
            r.value  = '0;
            if (op inside {OP_READ16, OP_READ8}) begin
                if (!reserved) begin
                    idx = find_live(tag);
                    if (idx < RECORDS_PER_BLOCK) begin
                        r.value = records[slot(bank, idx)][VAL_W-1:0];
                        if (op == OP_READ8) r.value[VAL_W-1:8] = '0;
                        r.status = ST_OK;
                    end
                end
            end else if (op == OP_WRITE && !reserved) begin
                if (fill >= RECORDS_PER_BLOCK) compact();
                if (fill >= RECORDS_PER_BLOCK) begin
                    r.status = ST_FULL;    // compaction stays in effect
                end else begin
                    old = find_live(tag);
                    records[slot(bank, fill)] = {tag, wval};
                    fill++;
                    // supersede: only the tag is cleared, value bits stay
                    if (old < RECORDS_PER_BLOCK)
                        records[slot(bank, old)][REC_W-1:VAL_W] = TAG_CLEARED;
                    stored_keys[int'(key)] = 1'b1;
                    r.status = ST_OK;
                end
            end
            replies_due.push_back(r);
        endfunction

        function void check_reply(logic [STAT_W-1:0] status, logic [VAL_W-1:0] value);
            t_kv_reply want;
            if (replies_due.size() == 0) begin
                $error("reply with nothing outstanding: status %0d read_value 0x%04h",
                       status, value);
                errors++;
                return;
            end
            want = replies_due.pop_front();
            if (status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, status);
                errors++;
            end
            if (value !== want.value) begin
                $error("read_value: expected 0x%04h, got 0x%04h", want.value, value);
                errors++;
            end
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // [1:0] opcode, [17:2] key, [33:18] write_value, upper bits zero
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [1:0] status, [17:2] read_value, upper bits zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    kv_scoreboard sb = new();

    bit          gaps_on = 1'b1;
    bit          stalls_on = 1'b1;
    int          quiet_words = 0;
    int          stall_left = 0;
    int          calm_left = 0;
    int unsigned cycles = 0;

    flash_kv_log_store i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("flash_kv_log_store verification failed");
            $finish;
        end
    end

    // Response side: check each accepted word, stall in random bursts
    // with occasional calm stretches.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_reply(m_axis_tdata[STAT_W-1:0], m_axis_tdata[STAT_W +: VAL_W]);
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (calm_left > 0 || !stalls_on) begin
                if (calm_left > 0) calm_left--;
                m_axis_tready <= 1'b1;
            end else if ($urandom_range(0, 15) == 0) begin
                stall_left = $urandom_range(0, 5);
                m_axis_tready <= 1'b0;
            end else begin
                if ($urandom_range(0, 63) == 0) calm_left = $urandom_range(50, 400);
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Offer one request word; valid stays high into the next word unless
    // a gap is inserted.
    task automatic send_word(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                             input logic [VAL_W-1:0] wval);
        int gap;
        gap = 0;
        if (quiet_words > 0) begin
            quiet_words--;
        end else if (gaps_on) begin
            if ($urandom_range(0, 11) == 0) quiet_words = $urandom_range(4, 24);
            else if ($urandom_range(0, 2) == 0) gap = $urandom_range(1, 6);
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'({wval, key, op});
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.apply_request(op, key, wval);
    endtask

    function automatic logic [VAL_W-1:0] random_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    function automatic logic [KEY_W-1:0] any_key();
        return KEY_W'($urandom_range(0, KEY_TOP));
    endfunction

    // a key with no record in the store yet
    function automatic logic [KEY_W-1:0] fresh_key();
        logic [KEY_W-1:0] k;
        do k = any_key(); while (sb.stored_keys.exists(int'(k)));
        return k;
    endfunction

    function automatic logic [OP_W-1:0] any_read();
        return $urandom_range(0, 1) ? OP_READ8 : OP_READ16;
    endfunction

    initial begin
        logic [KEY_W-1:0] hot [HOT_KEYS];
        int               useful;
        int               pick;

        hot[0] = '0;
        hot[1] = KEY_TOP;
        for (int i = 2; i < HOT_KEYS; i++) hot[i] = any_key();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty store, extremes, supersede, reserved keys, opcode 3
        send_word(OP_READ16, '0, '0);
        send_word(OP_UNUSED, '0, '0);
        send_word(OP_WRITE,  '0, 16'h0000);
        send_word(OP_READ16, '0, '0);
        send_word(OP_WRITE,  KEY_TOP, 16'hFFFF);
        send_word(OP_READ16, KEY_TOP, '0);
        send_word(OP_READ8,  KEY_TOP, '0);
        send_word(OP_WRITE,  '0, 16'hA5C3);
        send_word(OP_READ16, '0, '0);
        send_word(OP_READ8,  '0, '1);
        send_word(OP_WRITE,  KEY_RSVD_LO, 16'h1234);
        send_word(OP_WRITE,  KEY_RSVD_HI, 16'h5678);
        send_word(OP_READ16, KEY_RSVD_LO, '0);
        send_word(OP_READ8,  KEY_RSVD_HI, '0);
        send_word(OP_READ16, 16'd1, '0);
        send_word(OP_UNUSED, KEY_TOP, 16'hFFFF);
        send_word(OP_READ16, KEY_TOP, '0);
        send_word(OP_WRITE,  16'h5555, 16'hAAAA);
        send_word(OP_WRITE,  16'hAAAA, 16'h5555);
        send_word(OP_READ8,  16'h5555, '0);
        send_word(OP_READ16, 16'hAAAA, '0);

        // random traffic on a small hot set so reads hit and writes supersede
        useful = 0;
        while (useful < RANDOM_WORDS) begin
            pick = $urandom_range(0, 99);
            if (pick < 42) begin
                send_word(OP_WRITE, hot[$urandom_range(0, HOT_KEYS - 1)], random_value());
                useful++;
            end else if (pick < 86) begin
                send_word(any_read(), hot[$urandom_range(0, HOT_KEYS - 1)], random_value());
                useful++;
            end else if (pick < 91) begin
                send_word(OP_UNUSED, any_key(), random_value());
            end else if (pick < 95) begin
                send_word(OP_W'($urandom_range(0, 3)), $urandom_range(0, 1) ? KEY_RSVD_HI
                          : KEY_RSVD_LO, random_value());
            end else begin
                send_word(any_read(), any_key(), random_value());
                useful++;
            end
        end

        // fill the active block with new keys; superseded records pile up
        while (sb.fill < RECORDS_PER_BLOCK) begin
            if ($urandom_range(0, 31) == 0)
                send_word(any_read(), hot[$urandom_range(0, HOT_KEYS - 1)], random_value());
            else
                send_word(OP_WRITE, fresh_key(), random_value());
        end
        // block full: this write compacts into the spare block first
        send_word(OP_WRITE, fresh_key(), random_value());
        repeat (8) send_word(any_read(), hot[$urandom_range(0, HOT_KEYS - 1)], random_value());

        // refill with distinct live keys until compaction can free nothing
        while (sb.stored_keys.num() < RECORDS_PER_BLOCK) begin
            if ($urandom_range(0, 31) == 0)
                send_word(any_read(), hot[$urandom_range(0, HOT_KEYS - 1)], random_value());
            else
                send_word(OP_WRITE, fresh_key(), random_value());
        end

        // tail, no idling: writes now report full after a fruitless compaction
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        for (int n = 0; n < TAIL_WORDS; n++) begin
            pick = $urandom_range(0, 9);
            if (pick < 3)
                send_word(OP_WRITE, fresh_key(), random_value());
            else if (pick < 4)
                send_word(OP_WRITE, hot[$urandom_range(0, HOT_KEYS - 1)], random_value());
            else if (pick < 8)
                send_word(any_read(), hot[$urandom_range(0, HOT_KEYS - 1)], random_value());
            else if (pick < 9)
                send_word(any_read(), any_key(), random_value());
            else
                send_word(OP_UNUSED, any_key(), random_value());
        end
        s_axis_tvalid <= 1'b0;

        while (sb.replies_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0)
            $display("flash_kv_log_store verification clean");
        else
            $display("flash_kv_log_store verification failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/fkv_pkg.sv
rtl/flash_kv_log_store.sv
tb/tb.sv
